/* hw/rtl/pff_pkg.sv */
// shared constants, job descriptor and helper functions of the packet fragmenting framer
package pff_pkg;

    localparam int BUS_BUFFER_BYTES = 32;
    localparam int HEADER_BYTES     = 7;
    localparam logic [7:0] FRAG_PAYLOAD = 8'(BUS_BUFFER_BYTES - HEADER_BYTES);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [1:0] FLAG_SINGLE = 2'd0;
    localparam logic [1:0] FLAG_FRAG   = 2'd1;
    localparam logic [1:0] FLAG_LAST   = 2'd3;

    // one queue entry: everything the back end needs to emit the bytes of one input
    typedef struct packed {
        logic        has_hdr;
        logic [6:0]  src_addr;
        logic [1:0]  flag;
        logic [7:0]  opcode;
        logic [7:0]  msg_id;
        logic [15:0] csum;
        logic [7:0]  frag_len;
        logic        has_data;
        logic [7:0]  data;
        logic [1:0]  pad_cnt;
        logic        pkt_end;
        logic [6:0]  dest;
    } t_job;

    function automatic logic [7:0] frag_size(input logic [7:0] left);
        frag_size = (left > FRAG_PAYLOAD) ? FRAG_PAYLOAD : left;
    endfunction

    // inverted 16-bit sum over the header fields
    function automatic logic [15:0] header_csum(input logic [6:0] src, input logic [1:0] flag,
                                                input logic [7:0] opc, input logic [7:0] id,
                                                input logic [7:0] len);
        logic [15:0] s;
        s = {1'b0, src, 8'h00} + {8'h00, opc} + {(8'(flag) + len), 8'h00} + {8'h00, id};
        header_csum = ~s;
    endfunction

endpackage

/* hw/rtl/packet_fragmenting_framer.sv */
// top level of the packet fragmenting framer: front end, job queue and byte serializer
// Each accepted input beat is classified by the front end and, if it produces output,
// becomes one job in a four-entry queue; the back end then sends that job's bytes one
// per cycle, while the output is not stalled, through a registered output. A payload
// byte in the middle of a fragment costs one output byte, the first byte of a fragment
// costs eight (seven header bytes plus the byte), the last byte of a fragment adds up to
// three pad bytes, and an empty message costs eight; the back end's one-byte-per-cycle
// output port sets the sustained rate while not stalled: a full fragment of 25 payload
// beats gives 32 output bytes, while a one-byte message gives eight for its two input
// beats. Starts that open a message and stray payload bytes are absorbed with no output.
// The input stalls only while the queue is full. own_address is written through the
// config channel, which is always ready, and should only change while the block is idle.
module packet_fragmenting_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [6:0]  i_dest_address,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_msg_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [6:0]  o_out_dest,
    output logic        o_packet_end,
    output logic        o_last
);

    logic          q_full;
    logic          accept;
    logic          push;
    logic          pop;
    logic          head_valid;
    pff_pkg::t_job job;
    pff_pkg::t_job head;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    pff_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_op           (i_op),
        .i_dest_address (i_dest_address),
        .i_opcode       (i_opcode),
        .i_msg_length   (i_msg_length),
        .i_data_byte    (i_data_byte),
        .o_push         (push),
        .o_job          (job)
    );

    pff_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    pff_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_out_dest   (o_out_dest),
        .o_packet_end (o_packet_end),
        .o_last       (o_last)
    );

endmodule

/* hw/rtl/pff_front.sv */
// front end: config register, message tracking and job classification
module pff_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [6:0]        i_cfg_data,
    input  logic              i_accept,
    input  logic              i_op,
    input  logic [6:0]        i_dest_address,
    input  logic [7:0]        i_opcode,
    input  logic [7:0]        i_msg_length,
    input  logic [7:0]        i_data_byte,
    output logic              o_push,
    output pff_pkg::t_job     o_job
);

    logic [6:0] r_own_addr;
    logic [7:0] r_msg_id,     n_msg_id;
    logic       r_active,     n_active;
    logic [7:0] r_held_opc,   n_held_opc;
    logic [6:0] r_held_dest,  n_held_dest;
    logic [7:0] r_left,       n_left;
    logic [7:0] r_fill,       n_fill;
    logic [7:0] r_frag_len,   n_frag_len;
    logic       r_multi,      n_multi;

    logic [7:0] fill_inc;
    logic [7:0] left_dec;
    pff_pkg::t_job job;

    assign o_cfg_ready = 1'b1;
    assign fill_inc    = r_fill + 8'd1;
    assign left_dec    = r_left - 8'd1;

    always_comb begin
        n_msg_id    = r_msg_id;
        n_active    = r_active;
        n_held_opc  = r_held_opc;
        n_held_dest = r_held_dest;
        n_left      = r_left;
        n_fill      = r_fill;
        n_frag_len  = r_frag_len;
        n_multi     = r_multi;
        o_push      = 1'b0;

        job          = '0;
        job.src_addr = r_own_addr;
        job.msg_id   = r_msg_id;

        if (i_accept) begin
            if (i_op == pff_pkg::OP_START) begin
                n_active = 1'b0;
                if (i_msg_length == 8'd0) begin
                    // empty message: header plus one pad byte
                    o_push       = 1'b1;
                    job.has_hdr  = 1'b1;
                    job.flag     = pff_pkg::FLAG_SINGLE;
                    job.opcode   = i_opcode;
                    job.frag_len = 8'd0;
                    job.pad_cnt  = 2'd1;
                    job.pkt_end  = 1'b1;
                    job.dest     = i_dest_address;
                    n_msg_id     = r_msg_id + 8'd1;
                end else begin
                    n_active    = 1'b1;
                    n_held_dest = i_dest_address;
                    n_held_opc  = i_opcode;
                    n_left      = i_msg_length;
                    n_fill      = 8'd0;
                    n_frag_len  = pff_pkg::frag_size(i_msg_length);
                    n_multi     = i_msg_length > pff_pkg::FRAG_PAYLOAD;
                end
            end else if (r_active) begin
                o_push       = 1'b1;
                job.has_hdr  = r_fill == 8'd0;
                job.opcode   = r_held_opc;
                job.frag_len = r_frag_len;
                job.dest     = r_held_dest;
                job.has_data = 1'b1;
                job.data     = i_data_byte;
                if (r_multi) begin
                    job.flag = (r_left <= pff_pkg::FRAG_PAYLOAD) ? pff_pkg::FLAG_LAST
                                                                 : pff_pkg::FLAG_FRAG;
                end else begin
                    job.flag = pff_pkg::FLAG_SINGLE;
                end
                n_fill = fill_inc;
                n_left = left_dec;
                if (fill_inc >= r_frag_len) begin
                    // fragment complete: pad header plus payload to a multiple of four
                    job.pkt_end = 1'b1;
                    job.pad_cnt = 2'd1 - r_frag_len[1:0];
                    n_fill      = 8'd0;
                    if (left_dec == 8'd0) begin
                        n_active   = 1'b0;
                        n_frag_len = 8'd0;
                        n_msg_id   = r_msg_id + 8'd1;
                    end else begin
                        n_frag_len = pff_pkg::frag_size(left_dec);
                    end
                end
            end
        end

        job.csum = pff_pkg::header_csum(job.src_addr, job.flag, job.opcode, job.msg_id,
                                        job.frag_len);
        o_job = job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr  <= 7'd0;
            r_msg_id    <= 8'd0;
            r_active    <= 1'b0;
            r_held_opc  <= 8'd0;
            r_held_dest <= 7'd0;
            r_left      <= 8'd0;
            r_fill      <= 8'd0;
            r_frag_len  <= 8'd0;
            r_multi     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_own_addr <= i_cfg_data;
            end
            r_msg_id    <= n_msg_id;
            r_active    <= n_active;
            r_held_opc  <= n_held_opc;
            r_held_dest <= n_held_dest;
            r_left      <= n_left;
            r_fill      <= n_fill;
            r_frag_len  <= n_frag_len;
            r_multi     <= n_multi;
        end
    end

endmodule

/* hw/rtl/pff_queue.sv */
// small job queue between the front and back ends
module pff_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pff_pkg::t_job     i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_head_valid,
    output pff_pkg::t_job     o_head
);

    localparam int CW = $clog2(pff_pkg::QUEUE_DEPTH + 1);

    pff_pkg::t_job r_mem [pff_pkg::QUEUE_DEPTH];
    logic [pff_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [pff_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [CW-1:0]                r_count;

    assign o_full       = r_count == CW'(pff_pkg::QUEUE_DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_head_valid)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(pff_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

/* hw/rtl/pff_back.sv */
// back end: walks one job byte by byte into the output register
module pff_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  pff_pkg::t_job     i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic [6:0]        o_out_dest,
    output logic              o_packet_end,
    output logic              o_last
);

    typedef enum logic [3:0] {
        S_ADDR, S_FLAG, S_OPC, S_ID, S_CSH, S_CSL, S_LEN, S_DATA, S_PAD
    } t_step;

    t_step      r_step;
    logic       r_started;
    logic [1:0] r_pad_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [6:0] r_out_dest;
    logic       r_packet_end;
    logic       r_last;

    t_step      cur_step;
    t_step      n_step;
    logic [1:0] cur_pad;
    logic       load;
    logic       is_final;
    logic [7:0] byte_sel;

    assign load = i_head_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        if (r_started) begin
            cur_step = r_step;
            cur_pad  = r_pad_idx;
        end else begin
            cur_step = i_head.has_hdr ? S_ADDR : S_DATA;
            cur_pad  = 2'd0;
        end

        is_final = 1'b0;
        n_step   = cur_step;
        byte_sel = 8'h00;
        case (cur_step)
            S_ADDR: begin
                byte_sel = {1'b0, i_head.src_addr};
                n_step   = S_FLAG;
            end
            S_FLAG: begin
                byte_sel = {6'b0, i_head.flag};
                n_step   = S_OPC;
            end
            S_OPC: begin
                byte_sel = i_head.opcode;
                n_step   = S_ID;
            end
            S_ID: begin
                byte_sel = i_head.msg_id;
                n_step   = S_CSH;
            end
            S_CSH: begin
                byte_sel = i_head.csum[15:8];
                n_step   = S_CSL;
            end
            S_CSL: begin
                byte_sel = i_head.csum[7:0];
                n_step   = S_LEN;
            end
            S_LEN: begin
                byte_sel = i_head.frag_len;
                n_step   = i_head.has_data ? S_DATA : S_PAD;
                is_final = !i_head.has_data && i_head.pad_cnt == 2'd0;
            end
            S_DATA: begin
                byte_sel = i_head.data;
                n_step   = S_PAD;
                is_final = i_head.pad_cnt == 2'd0;
            end
            S_PAD: begin
                byte_sel = 8'h00;
                n_step   = S_PAD;
                is_final = cur_pad == i_head.pad_cnt - 2'd1;
            end
            default: begin
                byte_sel = 8'h00;
                n_step   = S_PAD;
                is_final = 1'b1;
            end
        endcase
    end

    assign o_pop = load && is_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_ADDR;
            r_started   <= 1'b0;
            r_pad_idx   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (is_final) begin
                    r_started <= 1'b0;
                    r_pad_idx <= 2'd0;
                end else begin
                    r_started <= 1'b1;
                    r_step    <= n_step;
                    r_pad_idx <= (cur_step == S_PAD) ? cur_pad + 2'd1 : 2'd0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte   <= byte_sel;
            r_out_dest   <= i_head.dest;
            r_packet_end <= is_final && i_head.pkt_end;
            r_last       <= is_final;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_dest   = r_out_dest;
    assign o_packet_end = r_packet_end;
    assign o_last       = r_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && cur_step == S_PAD |-> i_head.pad_cnt != 2'd0)
        else $error("pad beat for a job without padding");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && cur_step == S_DATA |-> i_head.has_data)
        else $error("data beat for a job without data");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && cur_step != S_DATA && cur_step != S_PAD |-> i_head.has_hdr)
        else $error("header beat for a job without header");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_head.pad_cnt != 2'd0 |-> i_head.pkt_end)
        else $error("padding on a job that does not close a packet");

endmodule

/* bench/packet_fragmenting_framer_tb.sv */
// self-checking testbench of the packet fragmenting framer: directed rows, random messages
module packet_fragmenting_framer_tb;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 24;
    localparam int MAX_PRINTS     = 50;

    localparam int STYLE_PLAIN    = 0;
    localparam int STYLE_PRESSURE = 1;
    localparam int STYLE_WRAP     = 2;

    typedef struct {
        bit [7:0] byte_val;
        bit [6:0] dest;
        bit       pkt_end;
        bit       last;
    } t_bus_byte;

    typedef struct {
        bit op;
        int dest;
        int opc;
        int len;
        int data;
        int n_out;
        int csum;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_op;
    logic [6:0] i_dest_address;
    logic [7:0] i_opcode;
    logic [7:0] i_msg_length;
    logic [7:0] i_data_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic [6:0] o_out_dest;
    logic       o_packet_end;
    logic       o_last;

    packet_fragmenting_framer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_dest_address (i_dest_address),
        .i_opcode       (i_opcode),
        .i_msg_length   (i_msg_length),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_out_dest     (o_out_dest),
        .o_packet_end   (o_packet_end),
        .o_last         (o_last)
    );

    // framer state as the bus should see it
    bit [6:0]  node_addr     = '0;
    bit [7:0]  msg_id        = '0;
    bit        msg_open      = 1'b0;
    bit [7:0]  msg_opcode    = '0;
    bit [6:0]  msg_dest      = '0;
    bit [7:0]  msg_left      = '0;
    bit [7:0]  frag_fill     = '0;
    bit [7:0]  frag_len      = '0;
    bit        multi_frag    = 1'b0;
    bit [15:0] last_hdr_csum = '0;

    t_bus_byte bus_bytes_due[$];

    int  mismatches   = 0;
    int  items_sent   = 0;
    int  beats_seen   = 0;
    int  packets_seen = 0;
    int  msgs_closed  = 0;
    int  id_wraps     = 0;
    int  addr_writes  = 0;
    bit  tx_idle      = 1'b1;
    bit  rx_idle      = 1'b1;
    bit  hold_req     = 1'b0;

    t_dir_row dir_rows [17] = '{
        '{pff_pkg::OP_START, 0,     8'h00, 0,   0,     8, 'hFFFF},
        '{pff_pkg::OP_START, 127,   8'hFF, 0,   0,     8, 'hFEFF},
        '{pff_pkg::OP_DATA,  0,     0,     0,   8'hFF, 0, -1},
        '{pff_pkg::OP_START, 5,     8'h12, 1,   0,     0, -1},
        '{pff_pkg::OP_DATA,  0,     0,     0,   8'hA5, 8, 'hFEEB},
        '{pff_pkg::OP_START, 127,   8'h80, 3,   0,     0, -1},
        '{pff_pkg::OP_DATA,  0,     0,     0,   8'h00, 8, 'hFC7C},
        '{pff_pkg::OP_DATA,  0,     0,     0,   8'h55, 1, -1},
        '{pff_pkg::OP_DATA,  0,     0,     0,   8'hFF, 3, -1},
        '{pff_pkg::OP_START, 1,     8'h02, 2,   0,     0, -1},
        '{pff_pkg::OP_DATA,  0,     0,     0,   8'h01, 8, 'hFDF9},
        '{pff_pkg::OP_START, 2,     8'h03, 0,   0,     8, 'hFFF8},
        '{pff_pkg::OP_START, 127,   8'hFF, 255, 0,     0, -1},
        '{pff_pkg::OP_DATA,  0,     0,     0,   8'h80, 8, 'hE4FB},
        '{pff_pkg::OP_DATA,  0,     0,     0,   8'h7F, 1, -1},
        '{pff_pkg::OP_START, 8'h2A, 8'hA5, 0,   0,     8, 'hFF55},
        '{pff_pkg::OP_DATA,  0,     0,     0,   8'h00, 0, -1}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 2_000_000);
        $display("Verification failed");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic int push_byte(input bit [7:0] b, input bit [6:0] dest, input bit pkt_end,
                                     input bit last);
        t_bus_byte e;
        e.byte_val = b;
        e.dest     = dest;
        e.pkt_end  = pkt_end;
        e.last     = last;
        bus_bytes_due.push_back(e);
        return 1;
    endfunction

    function automatic int push_header(input bit [1:0] flag, input bit [7:0] opc,
                                       input bit [6:0] dest, input bit [7:0] len);
        int s;
        int n;
        s = node_addr * 256 + opc + (flag + len) * 256 + msg_id;
        last_hdr_csum = ~s[15:0];
        n = 0;
        n += push_byte({1'b0, node_addr}, dest, 1'b0, 1'b0);
        n += push_byte({6'd0, flag}, dest, 1'b0, 1'b0);
        n += push_byte(opc, dest, 1'b0, 1'b0);
        n += push_byte(msg_id, dest, 1'b0, 1'b0);
        n += push_byte(last_hdr_csum[15:8], dest, 1'b0, 1'b0);
        n += push_byte(last_hdr_csum[7:0], dest, 1'b0, 1'b0);
        n += push_byte(len, dest, 1'b0, 1'b0);
        return n;
    endfunction

    // zero bytes up to the next multiple of 4, the final one ends packet and beat
    function automatic int push_pads(input int pads, input bit [6:0] dest);
        int n;
        n = 0;
        for (int i = 0; i < pads; i++)
            n += push_byte(8'h00, dest, i == pads - 1, i == pads - 1);
        return n;
    endfunction

    function automatic void close_message();
        msg_id++;
        msgs_closed++;
        if (msg_id == 8'd0)
            id_wraps++;
    endfunction

    // returns the number of bus bytes owed for one accepted input beat
    function automatic int frame_input(input bit op, input bit [6:0] dest, input bit [7:0] opc,
                                       input bit [7:0] len, input bit [7:0] data);
        int n;
        int pads;
        bit done;
        bit [1:0] flag;
        n = 0;
        if (op == pff_pkg::OP_START) begin
            msg_open = 1'b0;
            if (len == 8'd0) begin
                n += push_header(pff_pkg::FLAG_SINGLE, opc, dest, 8'd0);
                n += push_pads(1, dest);
                close_message();
            end else begin
                msg_open   = 1'b1;
                msg_dest   = dest;
                msg_opcode = opc;
                msg_left   = len;
                frag_fill  = '0;
                frag_len   = (len > pff_pkg::FRAG_PAYLOAD) ? pff_pkg::FRAG_PAYLOAD : len;
                multi_frag = len > pff_pkg::FRAG_PAYLOAD;
            end
        end else if (msg_open) begin
            if (frag_fill == 8'd0) begin
                flag = pff_pkg::FLAG_SINGLE;
                if (multi_frag)
                    flag = (msg_left <= pff_pkg::FRAG_PAYLOAD) ? pff_pkg::FLAG_LAST
                                                               : pff_pkg::FLAG_FRAG;
                n += push_header(flag, msg_opcode, msg_dest, frag_len);
            end
            frag_fill++;
            msg_left--;
            done = frag_fill >= frag_len;
            pads = (4 - ((pff_pkg::HEADER_BYTES + frag_len) % 4)) % 4;
            n += push_byte(data, msg_dest, done && pads == 0, !(done && pads > 0));
            if (done) begin
                n += push_pads(pads, msg_dest);
                frag_fill = '0;
                if (msg_left == 8'd0) begin
                    msg_open = 1'b0;
                    frag_len = '0;
                    close_message();
                end else begin
                    frag_len = (msg_left > pff_pkg::FRAG_PAYLOAD) ? pff_pkg::FRAG_PAYLOAD
                                                                 : msg_left;
                end
            end
        end
        return n;
    endfunction

    function automatic int tx_gap();
        int r;
        if (!tx_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        if (r < 50)
            return $urandom_range(1, 25);
        if (r < 78)
            return $urandom_range(26, 50);
        if (r < 97)
            return $urandom_range(51, 100);
        return $urandom_range(101, 140);
    endfunction

    task automatic offer_item(input bit op, input bit [6:0] dest, input bit [7:0] opc,
                              input bit [7:0] len, input bit [7:0] data, output int n);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_dest_address <= dest;
        i_opcode       <= opc;
        i_msg_length   <= len;
        i_data_byte    <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op == pff_pkg::OP_START || msg_open)
            items_sent++;
        n = frame_input(op, dest, opc, len, data);
    endtask

    // start beat, then n_bytes payload beats; fewer than len leaves the message unfinished
    task automatic send_message(input int len, input int n_bytes);
        int n;
        offer_item(pff_pkg::OP_START, 7'($urandom), 8'($urandom), 8'(len), 8'($urandom), n);
        for (int i = 0; i < n_bytes; i++)
            offer_item(pff_pkg::OP_DATA, 7'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), n);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (bus_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_own_address(input bit [6:0] a);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= a;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        node_addr = a;
        addr_writes++;
    endtask

    task automatic run_phase(input bit [6:0] addr, input bit idle_tx, input bit idle_rx,
                             input int style, input int budget);
        int first;
        int len;
        int n_bytes;
        int n;
        settle();
        write_own_address(addr);
        tx_idle = idle_tx;
        rx_idle = idle_rx;
        if (style == STYLE_PRESSURE) begin
            hold_req = 1'b1;
            send_message(60, 60);
        end
        first = items_sent;
        while (items_sent - first < budget || (style == STYLE_WRAP && id_wraps == 0)) begin
            if (!msg_open && $urandom_range(0, 99) < 5)
                offer_item(pff_pkg::OP_DATA, 7'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), n);
            if (style == STYLE_WRAP)
                len = ($urandom_range(0, 99) < 95) ? 0 : $urandom_range(1, 4);
            else
                len = pick_length();
            n_bytes = len;
            if (len > 1 && $urandom_range(0, 99) < 10)
                n_bytes = $urandom_range(1, len - 1);
            send_message(len, n_bytes);
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        int r;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (hold_req) begin
                hold_req    = 1'b0;
                i_out_stall <= 1'b1;
                stall_left  = HOLD_CYCLES - 1;
            end else if (rx_idle && !i_out_stall && $urandom_range(0, 99) < 20) begin
                r = $urandom_range(0, 99);
                i_out_stall <= 1'b1;
                stall_left  = (r < 85) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_bus_byte e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_seen++;
            if (o_packet_end)
                packets_seen++;
            if (bus_bytes_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected output beat byte %h", o_out_byte));
            end else begin
                e = bus_bytes_due.pop_front();
                if (o_out_byte !== e.byte_val)
                    flag_mismatch($sformatf("out_byte %h, want %h", o_out_byte, e.byte_val));
                if (o_out_dest !== e.dest)
                    flag_mismatch($sformatf("out_dest %h, want %h", o_out_dest, e.dest));
                if (o_packet_end !== e.pkt_end)
                    flag_mismatch($sformatf("packet_end %b, want %b", o_packet_end, e.pkt_end));
                if (o_last !== e.last)
                    flag_mismatch($sformatf("last %b, want %b", o_last, e.last));
            end
        end
    end

    initial begin
        int n;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_op           = pff_pkg::OP_START;
        i_dest_address = '0;
        i_opcode       = '0;
        i_msg_length   = '0;
        i_data_byte    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_own_address(7'h00);

        // directed rows: fixed counts and header checksums, bytes by the predictor
        foreach (dir_rows[r]) begin
            offer_item(dir_rows[r].op, 7'(dir_rows[r].dest), 8'(dir_rows[r].opc),
                       8'(dir_rows[r].len), 8'(dir_rows[r].data), n);
            if (n != dir_rows[r].n_out)
                flag_mismatch($sformatf("row %0d owes %0d beats, table says %0d",
                                        r, n, dir_rows[r].n_out));
            if (dir_rows[r].csum >= 0 && last_hdr_csum != 16'(dir_rows[r].csum))
                flag_mismatch($sformatf("row %0d checksum %h, table says %h",
                                        r, last_hdr_csum, 16'(dir_rows[r].csum)));
        end

        run_phase(7'h7F, 1'b1, 1'b1, STYLE_PLAIN, 40);
        run_phase(7'($urandom), 1'b0, 1'b0, STYLE_PLAIN, 40);
        run_phase(7'($urandom), 1'b0, 1'b1, STYLE_PRESSURE, 10);
        run_phase(7'($urandom), 1'b1, 1'b1, STYLE_WRAP, 30);
        run_phase(7'($urandom), 1'b1, 1'b1, STYLE_PLAIN, 20);
        settle();

        $display("run covered %0d input beats and %0d output beats in %0d bus packets",
                 items_sent, beats_seen, packets_seen);
        $display("%0d messages closed, message id wrapped %0d time(s), %0d address writes",
                 msgs_closed, id_wraps, addr_writes);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
